@@ hdl/spfs_pkg.sv @@
package spfs_pkg;

    localparam int SAMPLE_W      = 12;
    localparam int PERIOD_W      = 16;
    localparam int FRAME_BITS    = 52;
    localparam int WORD_A_BITS   = 21;
    localparam int WORD_B_BITS   = 31;
    localparam int STORE_DEPTH   = 3;
    localparam int COUNT_W       = 2;
    localparam int BIT_IDX_W     = $clog2(FRAME_BITS);
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd110;
    localparam logic [COUNT_W-1:0]  COUNT_FULL   = 2'd3;
    localparam logic [6:0]          SYNC_ONES    = 7'h7F;

    typedef logic [SAMPLE_W-1:0]   sample_t;
    typedef logic [PERIOD_W-1:0]   period_t;
    typedef logic [FRAME_BITS-1:0] frame_t;

    // front to queue
    typedef struct packed {
        logic   push;
        frame_t frame;
    } frame_push_t;

    // queue to back
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } queue_head_t;

    function automatic logic odd_ones(input sample_t s);
        return ^s;
    endfunction

    // 21-bit word of sync ones and sample 0, then 31-bit data word, msb goes out first
    function automatic frame_t build_frame(input sample_t s0, input sample_t s1,
                                           input sample_t s2);
        logic [WORD_A_BITS-1:0] word_a;
        logic [WORD_B_BITS-1:0] word_b;
        word_a = {SYNC_ONES, 1'b0, s0, odd_ones(s0)};
        // top bit of sample 1 is dropped but still counts in its parity
        word_b = {s1[SAMPLE_W-2:0], 1'b0, odd_ones(s1), s2, odd_ones(s2), 4'b0000, 1'b1};
        return {word_a, word_b};
    endfunction

endpackage

@@ hdl/spfs_front.sv @@
module spfs_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  spfs_pkg::sample_t     s_sample,
    input  logic                  q_ready,
    output spfs_pkg::frame_push_t push_out
);

    logic [spfs_pkg::COUNT_W-1:0] count_reg, count_next;
    spfs_pkg::sample_t            store_reg [spfs_pkg::STORE_DEPTH];
    logic                         accept;
    logic                         full;

    assign full    = (count_reg == spfs_pkg::COUNT_FULL);
    assign s_ready = !full || q_ready;
    assign accept  = s_valid && s_ready;

    assign push_out.push  = accept && full;
    assign push_out.frame = spfs_pkg::build_frame(store_reg[0], store_reg[1], store_reg[2]);

    always_comb begin
        count_next = count_reg;
        if (accept) begin
            if (full) begin
                count_next = spfs_pkg::COUNT_W'(1);
            end else begin
                count_next = count_reg + spfs_pkg::COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= spfs_pkg::COUNT_FULL;
            for (int i = 0; i < spfs_pkg::STORE_DEPTH; i++) begin
                store_reg[i] <= '0;
            end
        end else begin
            count_reg <= count_next;
            if (accept) begin
                // a full store restarts at entry 0 after the frame is taken
                if (full) begin
                    store_reg[0] <= s_sample;
                end else begin
                    store_reg[count_reg] <= s_sample;
                end
            end
        end
    end

endmodule

@@ hdl/spfs_queue.sv @@
module spfs_queue #(
    parameter int DEPTH = spfs_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  spfs_pkg::frame_push_t push_in,
    output logic                  q_ready,
    output spfs_pkg::queue_head_t head,
    input  logic                  pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    spfs_pkg::frame_t   slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               do_push, do_pop;

    assign q_ready    = (cnt_reg != CNT_W'(DEPTH));
    assign head.valid = (cnt_reg != '0);
    assign head.frame = slot_reg[rd_ptr_reg];
    assign do_push    = push_in.push && q_ready;
    assign do_pop     = pop && head.valid;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_in.frame;
        end
    end

endmodule

@@ hdl/spfs_back.sv @@
module spfs_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  spfs_pkg::period_t     cfg_bit_period,
    input  spfs_pkg::queue_head_t head,
    output logic                  pop,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_line_pos,
    output logic                  m_line_neg,
    output logic                  m_last_bit
);

    spfs_pkg::period_t                period_reg;
    spfs_pkg::period_t                timer_reg;
    spfs_pkg::period_t                hold_load;
    spfs_pkg::frame_t                 shift_reg;
    logic [spfs_pkg::BIT_IDX_W-1:0]   left_reg;
    logic                             busy_reg;
    logic                             beat_done;
    logic                             last;

    assign cfg_ready = 1'b1;

    // a period of 0 paces like 1
    assign hold_load = (period_reg == '0) ? '0 : period_reg - spfs_pkg::PERIOD_W'(1);

    assign last      = (left_reg == '0);
    assign m_valid   = busy_reg && (timer_reg == '0);
    assign beat_done = m_valid && m_ready;
    assign pop       = head.valid && (!busy_reg || (beat_done && last));

    assign m_line_pos = shift_reg[spfs_pkg::FRAME_BITS-1];
    assign m_line_neg = ~shift_reg[spfs_pkg::FRAME_BITS-1];
    assign m_last_bit = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= spfs_pkg::PERIOD_RESET;
            busy_reg   <= 1'b0;
            timer_reg  <= '0;
            left_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                period_reg <= cfg_bit_period;
            end
            if (pop) begin
                busy_reg  <= 1'b1;
                timer_reg <= hold_load;
                left_reg  <= spfs_pkg::BIT_IDX_W'(spfs_pkg::FRAME_BITS - 1);
            end else if (beat_done) begin
                if (last) begin
                    busy_reg <= 1'b0;
                end else begin
                    timer_reg <= hold_load;
                    left_reg  <= left_reg - spfs_pkg::BIT_IDX_W'(1);
                end
            end else if (busy_reg && timer_reg != '0) begin
                timer_reg <= timer_reg - spfs_pkg::PERIOD_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            shift_reg <= head.frame;
        end else if (beat_done && !last) begin
            shift_reg <= {shift_reg[spfs_pkg::FRAME_BITS-2:0], 1'b0};
        end
    end

endmodule

@@ hdl/sample_parity_frame_serializer.sv @@
// sample parity frame serializer
//
// input channel (s_valid / s_ready / s_sample): one 12-bit converter sample per beat.
// samples fill a three-entry store; the sample that arrives when the store is full
// first launches a 52-bit frame of the stored samples, then starts a new fill.
// the first sample after reset launches a frame of cleared samples.
// output channel (m_valid / m_ready): one beat per frame bit, msb first, on the
// complementary pair m_line_pos / m_line_neg, with m_last_bit on the 52nd bit.
// config channel (cfg_valid / cfg_ready / cfg_bit_period): always ready; sets the
// bit period that paces how long each bit is held before its beat (0 acts as 1).
// with the serializer idle, the launching sample's frame goes through the queue into
// the shift register, and m_valid rises once the bit timer has run down.
// the frame queue in between lets the input take a sample every cycle until
// QUEUE_DEPTH frames are waiting, then s_ready drops only for launching samples.
// a stalled receiver holds the current bit; reset (aresetn low, synchronous)
// clears the store, sets the fill count to full, empties the queue, period 110.
module sample_parity_frame_serializer #(
    parameter int QUEUE_DEPTH = spfs_pkg::QUEUE_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    // sample beats
    input  logic              s_valid,
    output logic              s_ready,
    input  spfs_pkg::sample_t s_sample,
    // bit beats
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_line_pos,
    output logic              m_line_neg,
    output logic              m_last_bit,
    // bit period register
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  spfs_pkg::period_t cfg_bit_period
);

    spfs_pkg::frame_push_t push;
    spfs_pkg::queue_head_t head;
    logic                  q_ready;
    logic                  pop;

    // front: sample store, fill count, frame assembly
    spfs_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_sample (s_sample),
        .q_ready  (q_ready),
        .push_out (push)
    );

    // short frame queue decouples sample intake from the serializer
    spfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push_in (push),
        .q_ready (q_ready),
        .head    (head),
        .pop     (pop)
    );

    // back: bit pacing and shift out
    spfs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_bit_period (cfg_bit_period),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_pos     (m_line_pos),
        .m_line_neg     (m_line_neg),
        .m_last_bit     (m_last_bit)
    );

endmodule

@@ hdl/spfs_checker.sv @@
module spfs_checker (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input logic m_line_pos,
    input logic m_line_neg,
    input logic m_last_bit
);

    localparam int IDX_W = spfs_pkg::BIT_IDX_W;

    logic [IDX_W-1:0] beat_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beat_cnt_reg <= '0;
        end else if (m_valid && m_ready) begin
            if (beat_cnt_reg == IDX_W'(spfs_pkg::FRAME_BITS - 1)) begin
                beat_cnt_reg <= '0;
            end else begin
                beat_cnt_reg <= beat_cnt_reg + IDX_W'(1);
            end
        end
    end

    a_valid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("bit beat withdrawn while stalled");

    a_bit_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_line_pos) && $stable(m_last_bit))
        else $error("bit beat changed while stalled");

    a_last_place: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last_bit == (beat_cnt_reg == IDX_W'(spfs_pkg::FRAME_BITS - 1))))
        else $error("last bit flag off the frame boundary");

    a_sync_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (beat_cnt_reg < IDX_W'(7)) |-> m_line_pos && !m_line_neg)
        else $error("sync ones missing at frame start");

    a_stop_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_bit |-> m_line_pos && !m_line_neg)
        else $error("frame does not end in a one");

endmodule

bind sample_parity_frame_serializer spfs_checker u_spfs_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_line_pos (m_line_pos),
    .m_line_neg (m_line_neg),
    .m_last_bit (m_last_bit)
);
